// ===== design/ght_pkg.sv =====
// Shared types and constants for the generational handle table.
package ght_pkg;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 10;
    localparam int GEN_W    = 16;
    localparam int OBJ_W    = 32;
    localparam int FRESH_CAP = 65535;

    typedef enum logic [CMD_W-1:0] {
        CMD_REGISTER   = 3'd0,
        CMD_WRAP       = 3'd1,
        CMD_RESOLVE    = 3'd2,
        CMD_RELEASE    = 3'd3,
        CMD_UNREGISTER = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_NULL = 2'd1,
        ST_FULL = 2'd2,
        ST_MISS = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    typedef struct packed {
        status_t status;
        logic    alloc;
        logic    pop;
        logic    fresh;
        logic    wrap_hit;
        logic    found;
        logic    release_slot;
    } ght_ctrl_t;

endpackage

// ===== design/ght_exec.sv =====
// Command decode: picks the action and status of one item from the read slot data.
module ght_exec (
    input  logic [ght_pkg::CMD_W-1:0] cmd,
    input  logic                      obj_null,
    input  logic                      sel_zero,
    input  logic                      idx_ok,
    input  logic                      obj_match,
    input  logic                      gen_match,
    input  logic                      slot_occ,
    input  logic                      can_pop,
    input  logic                      fresh_ok,
    output ght_pkg::ght_ctrl_t        ctrl
);
    import ght_pkg::*;

    ght_ctrl_t alloc_ctrl;

    always_comb
    begin
        alloc_ctrl = '0;
        alloc_ctrl.status = ST_FULL;
        if (can_pop)
        begin
            alloc_ctrl.status = ST_OK;
            alloc_ctrl.alloc  = 1'b1;
            alloc_ctrl.pop    = 1'b1;
        end
        else if (fresh_ok)
        begin
            alloc_ctrl.status = ST_OK;
            alloc_ctrl.alloc  = 1'b1;
            alloc_ctrl.fresh  = 1'b1;
        end
    end

    always_comb
    begin
        ctrl = '0;
        ctrl.status = ST_MISS;
        case (cmd)
            CMD_REGISTER:
            begin
                if (obj_null)
                    ctrl.status = ST_NULL;
                else
                    ctrl = alloc_ctrl;
            end
            CMD_WRAP:
            begin
                if (obj_null)
                    ctrl.status = ST_NULL;
                else if (idx_ok && obj_match)
                begin
                    ctrl.status   = ST_OK;
                    ctrl.wrap_hit = 1'b1;
                end
                else
                    ctrl = alloc_ctrl;
            end
            CMD_RESOLVE, CMD_RELEASE:
            begin
                if (sel_zero)
                    ctrl.status = ST_NULL;
                else if (idx_ok && gen_match && slot_occ)
                begin
                    ctrl.status       = ST_OK;
                    ctrl.found        = 1'b1;
                    ctrl.release_slot = (cmd == CMD_RELEASE);
                end
            end
            CMD_UNREGISTER:
            begin
                if (obj_null)
                    ctrl.status = ST_NULL;
                else if (idx_ok && obj_match)
                begin
                    ctrl.status       = ST_OK;
                    ctrl.release_slot = 1'b1;
                end
            end
            default:
            begin
                ctrl.status = ST_MISS;
            end
        endcase
    end

endmodule

// ===== design/generational_handle_table_core.sv =====
// Generational handle table top level: slot memory, free stack and command sequencing.
// Each item is accepted while busy is low, and the slot memory and free-stack memory
// are read at that edge; in the following cycle (busy high) the read data is checked,
// the memories are written back as the command needs and the counters advance. The
// result is on the result ports with done high for the cycle after that, and a new item
// may be accepted in that same cycle; no item is accepted while busy is high. The
// receiver cannot stall results. No clearing pass follows reset: a fresh slot is written
// with generation zero on first use, and slots past the fresh mark are never looked at.
module generational_handle_table_core #(
    parameter int SLOT_COUNT = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [ght_pkg::CMD_W-1:0]    command,
    input  logic [ght_pkg::OBJ_W-1:0]    object_id,
    input  logic [ght_pkg::IDX_W-1:0]    known_index,
    input  logic [ght_pkg::IDX_W-1:0]    handle_index,
    input  logic [ght_pkg::GEN_W-1:0]    handle_generation,
    output logic                         done,
    output logic [ght_pkg::STATUS_W-1:0] status,
    output logic [ght_pkg::IDX_W-1:0]    result_index,
    output logic [ght_pkg::GEN_W-1:0]    result_generation,
    output logic [ght_pkg::OBJ_W-1:0]    resolved_object,
    output logic [ght_pkg::IDX_W-1:0]    live_count
);
    import ght_pkg::*;

    localparam int SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int FRESH_LIMIT = (SLOT_COUNT < FRESH_CAP) ? SLOT_COUNT : FRESH_CAP;
    localparam int SLOT_W  = OBJ_W + GEN_W;
    localparam int STACK_W = SW + GEN_W;

    logic [SLOT_W-1:0]  slot_mem [SLOT_COUNT];
    logic [STACK_W-1:0] stack_mem [SLOT_COUNT];

    state_t              state_reg, state_next;
    logic [CMD_W-1:0]    cmd_reg;
    logic [OBJ_W-1:0]    obj_reg;
    logic [IDX_W-1:0]    sel_reg;
    logic [GEN_W-1:0]    hgen_reg;
    logic [SLOT_W-1:0]   slot_rd_reg;
    logic [STACK_W-1:0]  stack_rd_reg;
    logic [CNT_W-1:0]    free_depth_reg, free_depth_next;
    logic [CNT_W-1:0]    next_fresh_reg, next_fresh_next;
    logic [CNT_W-1:0]    occ_reg, occ_next;
    logic                done_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [IDX_W-1:0]    rindex_reg;
    logic [GEN_W-1:0]    rgen_reg;
    logic [OBJ_W-1:0]    robj_reg;
    logic [IDX_W-1:0]    live_reg;

    logic                accept;
    logic [IDX_W-1:0]    sel_in;
    logic [CMP_W-1:0]    rd_addr_full;
    logic [CNT_W-1:0]    depth_m1;
    logic [OBJ_W-1:0]    rd_obj;
    logic [GEN_W-1:0]    rd_gen;
    logic [GEN_W-1:0]    bumped_gen;
    logic [SW-1:0]       pop_idx;
    logic [GEN_W-1:0]    pop_gen;
    logic [CMP_W-1:0]    sel_full;
    logic                idx_ok;
    logic                can_push;
    ght_ctrl_t           ctrl;
    logic [CMP_W-1:0]    ri_full;
    logic [GEN_W-1:0]    rg_val;
    logic                slot_we;
    logic [CMP_W-1:0]    slot_waddr_full;
    logic [SLOT_W-1:0]   slot_wdata;
    logic                stack_we;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg == S_EXEC);

    assign sel_in = (command == CMD_WRAP || command == CMD_UNREGISTER) ? known_index
                                                                       : handle_index;
    assign rd_addr_full = CMP_W'(sel_in);
    assign depth_m1     = free_depth_reg - CNT_W'(1);

    assign rd_obj     = slot_rd_reg[SLOT_W-1:GEN_W];
    assign rd_gen     = slot_rd_reg[GEN_W-1:0];
    assign bumped_gen = rd_gen + GEN_W'(1);
    assign pop_idx    = stack_rd_reg[STACK_W-1:GEN_W];
    assign pop_gen    = stack_rd_reg[GEN_W-1:0];

    assign sel_full = CMP_W'(sel_reg);
    assign idx_ok   = (sel_full != '0) && (sel_full < CMP_W'(next_fresh_reg))
                      && (sel_full < CMP_W'(SLOT_COUNT));
    assign can_push = (free_depth_reg < CNT_W'(SLOT_COUNT));

    ght_exec u_exec (
        .cmd       (cmd_reg),
        .obj_null  (obj_reg == '0),
        .sel_zero  (sel_reg == '0),
        .idx_ok    (idx_ok),
        .obj_match (rd_obj == obj_reg),
        .gen_match (rd_gen == hgen_reg),
        .slot_occ  (rd_obj != '0),
        .can_pop   (free_depth_reg != '0),
        .fresh_ok  (next_fresh_reg < CNT_W'(FRESH_LIMIT)),
        .ctrl      (ctrl)
    );

    always_comb
    begin
        ri_full = '0;
        rg_val  = '0;
        if (ctrl.pop)
        begin
            ri_full = CMP_W'(pop_idx);
            rg_val  = pop_gen;
        end
        else if (ctrl.fresh)
        begin
            ri_full = CMP_W'(next_fresh_reg);
        end
        else if (ctrl.wrap_hit)
        begin
            ri_full = sel_full;
            rg_val  = rd_gen;
        end
    end

    always_comb
    begin
        slot_we         = 1'b0;
        slot_waddr_full = sel_full;
        slot_wdata      = {{OBJ_W{1'b0}}, bumped_gen};
        stack_we        = 1'b0;
        if (state_reg == S_EXEC)
        begin
            if (ctrl.alloc)
            begin
                slot_we         = 1'b1;
                slot_waddr_full = ri_full;
                slot_wdata      = {obj_reg, rg_val};
            end
            else if (ctrl.release_slot)
            begin
                slot_we  = 1'b1;
                stack_we = can_push;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_waddr_full[SW-1:0]] <= slot_wdata;
        if (accept)
            slot_rd_reg <= slot_mem[rd_addr_full[SW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
            stack_mem[free_depth_reg[SW-1:0]] <= {sel_full[SW-1:0], bumped_gen};
        if (accept)
            stack_rd_reg <= stack_mem[depth_m1[SW-1:0]];
    end

    always_comb
    begin
        state_next      = state_reg;
        free_depth_next = free_depth_reg;
        next_fresh_next = next_fresh_reg;
        occ_next        = occ_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                if (ctrl.pop)
                    free_depth_next = depth_m1;
                else if (ctrl.release_slot && can_push)
                    free_depth_next = free_depth_reg + CNT_W'(1);
                if (ctrl.fresh)
                    next_fresh_next = next_fresh_reg + CNT_W'(1);
                if (ctrl.alloc)
                    occ_next = occ_reg + CNT_W'(1);
                else if (ctrl.release_slot && occ_reg != '0)
                    occ_next = occ_reg - CNT_W'(1);
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            free_depth_reg <= '0;
            next_fresh_reg <= CNT_W'(1);
            occ_reg        <= '0;
            done_reg       <= 1'b0;
            live_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            free_depth_reg <= free_depth_next;
            next_fresh_reg <= next_fresh_next;
            occ_reg        <= occ_next;
            done_reg       <= (state_reg == S_EXEC);
            if (state_reg == S_EXEC)
                live_reg <= IDX_W'(occ_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            obj_reg  <= object_id;
            sel_reg  <= sel_in;
            hgen_reg <= handle_generation;
        end
        if (state_reg == S_EXEC)
        begin
            status_reg <= ctrl.status;
            rindex_reg <= IDX_W'(ri_full);
            rgen_reg   <= rg_val;
            robj_reg   <= ctrl.found ? rd_obj : '0;
        end
    end

    assign done              = done_reg;
    assign status            = status_reg;
    assign result_index      = rindex_reg;
    assign result_generation = rgen_reg;
    assign resolved_object   = robj_reg;
    assign live_count        = live_reg;

endmodule

// ===== design/ght_checker.sv =====
// Port-level checks for the generational handle table, bound to the top level.
module ght_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic [ght_pkg::STATUS_W-1:0] status,
    input logic [ght_pkg::IDX_W-1:0]    result_index,
    input logic [ght_pkg::GEN_W-1:0]    result_generation,
    input logic [ght_pkg::IDX_W-1:0]    live_count
);
    import ght_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("result did not follow the execute cycle");

    a_fail_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (result_index == '0))
        else $error("failed item returned a handle");

    a_null_gen: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result_index == '0) |-> (result_generation == '0))
        else $error("null handle carries a generation");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> $stable(live_count))
        else $error("live count moved without an item");

endmodule

bind generational_handle_table_core ght_checker u_ght_checker (.*);
